// File: rtl/core/msc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// msc_pkg
// Shared types, codes and reset values of the motor speed command controller.
// ---------------------------------------------------------------------------
package msc_pkg;

  localparam int unsigned ID_W    = 11;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SPD_W   = 16;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDATA_W = 16;

  // item kinds
  localparam logic [FUNC_W-1:0] FUNC_FRAME  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd2;

  // command codes
  localparam logic [BYTE_W-1:0] OP_SPEED  = 8'h30;
  localparam logic [BYTE_W-1:0] OP_DIR    = 8'h31;
  localparam logic [BYTE_W-1:0] OP_STOP   = 8'h32;
  localparam logic [BYTE_W-1:0] OP_STATUS = 8'h33;

  // result destinations
  localparam logic TGT_REPLY = 1'b0;
  localparam logic TGT_DRIVE = 1'b1;

  // reply kinds
  localparam logic [KIND_W-1:0] KIND_SPEED_ACK = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DIR_ACK   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STOP_ACK  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STATUS    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR     = 3'd4;

  // status codes
  localparam logic [BYTE_W-1:0] ST_OK      = 8'd0;
  localparam logic [BYTE_W-1:0] ST_EMPTY   = 8'd1;
  localparam logic [BYTE_W-1:0] ST_SHORT   = 8'd2;
  localparam logic [BYTE_W-1:0] ST_UNKNOWN = 8'd3;

  // configuration register indices
  localparam logic [CIDX_W-1:0] CFG_NODE_ADDR   = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_MAX_SPEED   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_RAMP_STEP   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_RAMP_IVL    = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_REFRESH_IVL = 3'd4;

  // configuration reset values
  localparam logic [ID_W-1:0]  RST_NODE_ADDR   = 11'h311;
  localparam logic [SPD_W-1:0] RST_MAX_SPEED   = 16'd1500;
  localparam logic [SPD_W-1:0] RST_RAMP_STEP   = 16'd30;
  localparam logic [SPD_W-1:0] RST_RAMP_IVL    = 16'd600;
  localparam logic [SPD_W-1:0] RST_REFRESH_IVL = 16'd300;

  localparam logic [SPD_W-1:0] TIMER_MAX  = 16'hFFFF;
  localparam logic [SPD_W-1:0] SPEED_MASK = 16'h7FFF;

  typedef struct packed {
    logic              target;
    logic [KIND_W-1:0] reply_kind;
    logic [SPD_W-1:0]  word_one;
    logic [SPD_W-1:0]  word_two;
    logic [BYTE_W-1:0] status_code;
    logic              clockwise;
    logic [SPD_W-1:0]  drive_speed;
    logic              last;
  } res_t;

  function automatic res_t mk_drive(input logic cw, input logic [SPD_W-1:0] spd);
    res_t r;
    r             = '0;
    r.target      = TGT_DRIVE;
    r.clockwise   = cw;
    r.drive_speed = spd;
    return r;
  endfunction

  function automatic res_t mk_reply(input logic [KIND_W-1:0] kind,
                                    input logic [SPD_W-1:0]  w1,
                                    input logic [SPD_W-1:0]  w2,
                                    input logic [BYTE_W-1:0] st);
    res_t r;
    r             = '0;
    r.target      = TGT_REPLY;
    r.reply_kind  = kind;
    r.word_one    = w1;
    r.word_two    = w2;
    r.status_code = st;
    return r;
  endfunction

endpackage

// File: rtl/core/msc_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// msc_if
// Valid/ready channels of the controller: input items, results, configuration.
// ---------------------------------------------------------------------------
interface msc_in_if import msc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   frame_id;
  logic [LEN_W-1:0]  frame_length;
  logic [BYTE_W-1:0] opcode_byte;
  logic [BYTE_W-1:0] arg_high;
  logic [BYTE_W-1:0] arg_low;
  logic [SPD_W-1:0]  reported_speed;
  logic [BYTE_W-1:0] reported_fault;

  modport source (output valid, func, frame_id, frame_length, opcode_byte, arg_high,
                  arg_low, reported_speed, reported_fault, input ready);
  modport sink   (input valid, func, frame_id, frame_length, opcode_byte, arg_high,
                  arg_low, reported_speed, reported_fault, output ready);
endinterface

interface msc_out_if import msc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              target;
  logic [KIND_W-1:0] reply_kind;
  logic [SPD_W-1:0]  word_one;
  logic [SPD_W-1:0]  word_two;
  logic [BYTE_W-1:0] status_code;
  logic              clockwise;
  logic [SPD_W-1:0]  drive_speed;
  logic              last;

  modport source (output valid, target, reply_kind, word_one, word_two, status_code,
                  clockwise, drive_speed, last, input ready);
  modport sink   (input valid, target, reply_kind, word_one, word_two, status_code,
                  clockwise, drive_speed, last, output ready);
endinterface

interface msc_cfg_if import msc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  idx;
  logic [CDATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

// File: rtl/core/motor_speed_command_controller_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// motor_speed_command_controller_unit
// Motor speed command controller: command frames, ticks and inverter reports.
// ---------------------------------------------------------------------------
// Each input transaction is decoded in the cycle it is accepted: the state is
// updated at that edge and its zero, one or two results are written into a
// two-entry result register. Results leave one per cycle while out_ch.ready
// is high, a drive command ahead of its reply, with last set on the final
// result of the transaction. An item that gives one result or none can be
// followed by a new transaction in the next cycle; one that gives two holds
// off the next transaction until its first result has left. The result
// register count is what sets this limit. in_ch.ready depends on out_ch.ready
// only while a single result is left. The configuration port is always ready;
// writes to indices beyond the register list are dropped.
// ---------------------------------------------------------------------------
module motor_speed_command_controller_unit import msc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  msc_in_if.sink    in_ch,
  msc_out_if.source out_ch,
  msc_cfg_if.sink   cfg_ch
);

  // configuration registers
  logic [ID_W-1:0]  node_addr_r;
  logic [SPD_W-1:0] max_speed_r;
  logic [SPD_W-1:0] ramp_step_r;
  logic [SPD_W-1:0] ramp_ivl_r;
  logic [SPD_W-1:0] refresh_ivl_r;

  // controller state
  logic [SPD_W-1:0]  set_speed_r,     set_speed_nxt;
  logic [SPD_W-1:0]  goal_speed_r,    goal_speed_nxt;
  logic              dir_cw_r,        dir_cw_nxt;
  logic              ramping_r,       ramping_nxt;
  logic [SPD_W-1:0]  ramp_timer_r,    ramp_timer_nxt;
  logic [SPD_W-1:0]  refresh_timer_r, refresh_timer_nxt;
  logic [SPD_W-1:0]  actual_speed_r,  actual_speed_nxt;
  logic [BYTE_W-1:0] fault_r,         fault_nxt;

  // result register: slot 0 is at the output
  res_t       slot0_r, slot1_r;
  logic [1:0] cnt_r;

  res_t       res0, res1;
  logic [1:0] res_cnt;

  logic in_fire, out_fire;

  // working values of the decode
  logic [SPD_W-1:0] req;
  logic [SPD_W-1:0] clamped;
  logic [SPD_W:0]   ramp_floor;
  logic [SPD_W-1:0] ramp_t_inc;
  logic [SPD_W-1:0] ref_t_inc;
  logic [SPD_W-1:0] step_speed;
  logic             frame_ok;

  // handshake
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ch.ready);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_ch.valid && out_ch.ready;

  assign out_ch.valid       = (cnt_r != 2'd0);
  assign out_ch.target      = slot0_r.target;
  assign out_ch.reply_kind  = slot0_r.reply_kind;
  assign out_ch.word_one    = slot0_r.word_one;
  assign out_ch.word_two    = slot0_r.word_two;
  assign out_ch.status_code = slot0_r.status_code;
  assign out_ch.clockwise   = slot0_r.clockwise;
  assign out_ch.drive_speed = slot0_r.drive_speed;
  assign out_ch.last        = slot0_r.last;

  // decode of one transaction
  always_comb begin
    set_speed_nxt     = set_speed_r;
    goal_speed_nxt    = goal_speed_r;
    dir_cw_nxt        = dir_cw_r;
    ramping_nxt       = ramping_r;
    ramp_timer_nxt    = ramp_timer_r;
    refresh_timer_nxt = refresh_timer_r;
    actual_speed_nxt  = actual_speed_r;
    fault_nxt         = fault_r;
    res0              = '0;
    res1              = '0;
    res_cnt           = 2'd0;

    req        = {in_ch.arg_high, in_ch.arg_low};
    clamped    = (req > max_speed_r) ? max_speed_r : req;
    // goal plus step, kept unwrapped
    ramp_floor = {1'b0, goal_speed_r} + {1'b0, ramp_step_r};
    ramp_t_inc = (ramp_timer_r == TIMER_MAX) ? ramp_timer_r : ramp_timer_r + 16'd1;
    ref_t_inc  = (refresh_timer_r == TIMER_MAX) ? refresh_timer_r : refresh_timer_r + 16'd1;
    step_speed = set_speed_r;
    frame_ok   = (in_ch.frame_id == node_addr_r);

    case (in_ch.func)
      FUNC_FRAME: begin
        if (frame_ok) begin
          if (in_ch.frame_length == 4'd0) begin
            res0    = mk_reply(KIND_ERROR, '0, '0, ST_EMPTY);
            res_cnt = 2'd1;
          end else begin
            case (in_ch.opcode_byte)
              OP_SPEED: begin
                if (in_ch.frame_length >= 4'd3) begin
                  goal_speed_nxt = clamped;
                  if (clamped < set_speed_r) begin
                    // lower speed: ramp down, ack only
                    ramping_nxt    = 1'b1;
                    ramp_timer_nxt = '0;
                    res0           = mk_reply(KIND_SPEED_ACK, req, '0, ST_OK);
                    res_cnt        = 2'd1;
                  end else begin
                    set_speed_nxt = clamped;
                    ramping_nxt   = 1'b0;
                    res0          = mk_drive(dir_cw_r, clamped);
                    res1          = mk_reply(KIND_SPEED_ACK, req, '0, ST_OK);
                    res_cnt       = 2'd2;
                  end
                end else begin
                  res0    = mk_reply(KIND_ERROR, '0, '0, ST_SHORT);
                  res_cnt = 2'd1;
                end
              end
              OP_DIR: begin
                if (in_ch.frame_length >= 4'd2) begin
                  dir_cw_nxt = (in_ch.arg_high != 8'd0);
                  res0       = mk_drive(dir_cw_nxt, set_speed_r);
                  res1       = mk_reply(KIND_DIR_ACK, {15'd0, dir_cw_nxt}, '0, ST_OK);
                  res_cnt    = 2'd2;
                end else begin
                  res0    = mk_reply(KIND_ERROR, '0, '0, ST_SHORT);
                  res_cnt = 2'd1;
                end
              end
              OP_STOP: begin
                set_speed_nxt  = '0;
                goal_speed_nxt = '0;
                ramping_nxt    = 1'b0;
                res0           = mk_drive(dir_cw_r, '0);
                res1           = mk_reply(KIND_STOP_ACK, '0, '0, ST_OK);
                res_cnt        = 2'd2;
              end
              OP_STATUS: begin
                res0    = mk_reply(KIND_STATUS, actual_speed_r,
                                   {dir_cw_r, set_speed_r[SPD_W-2:0]}, fault_r);
                res_cnt = 2'd1;
              end
              default: begin
                res0    = mk_reply(KIND_ERROR, '0, '0, ST_UNKNOWN);
                res_cnt = 2'd1;
              end
            endcase
          end
        end
      end
      FUNC_TICK: begin
        if (ramping_r) begin
          ramp_timer_nxt = ramp_t_inc;
          if (ramp_t_inc > ramp_ivl_r) begin
            ramp_timer_nxt = '0;
            if ({1'b0, set_speed_r} > ramp_floor) begin
              step_speed = set_speed_r - ramp_step_r;
            end else begin
              step_speed  = goal_speed_r;
              ramping_nxt = 1'b0;
            end
            set_speed_nxt = step_speed;
            res0          = mk_drive(dir_cw_r, step_speed);
            res_cnt       = 2'd1;
          end
        end
        refresh_timer_nxt = ref_t_inc;
        if (ref_t_inc > refresh_ivl_r) begin
          refresh_timer_nxt = '0;
          // refresh goes after any ramp step drive
          if (res_cnt == 2'd1) begin
            res1    = mk_drive(dir_cw_r, step_speed);
            res_cnt = 2'd2;
          end else begin
            res0    = mk_drive(dir_cw_r, step_speed);
            res_cnt = 2'd1;
          end
        end
      end
      FUNC_REPORT: begin
        actual_speed_nxt = in_ch.reported_speed;
        fault_nxt        = in_ch.reported_fault;
      end
      default: begin
      end
    endcase

    res0.last = (res_cnt == 2'd1);
    res1.last = 1'b1;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_addr_r   <= RST_NODE_ADDR;
      max_speed_r   <= RST_MAX_SPEED;
      ramp_step_r   <= RST_RAMP_STEP;
      ramp_ivl_r    <= RST_RAMP_IVL;
      refresh_ivl_r <= RST_REFRESH_IVL;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.idx)
        CFG_NODE_ADDR:   node_addr_r   <= cfg_ch.data[ID_W-1:0];
        CFG_MAX_SPEED:   max_speed_r   <= cfg_ch.data;
        CFG_RAMP_STEP:   ramp_step_r   <= cfg_ch.data;
        CFG_RAMP_IVL:    ramp_ivl_r    <= cfg_ch.data;
        CFG_REFRESH_IVL: refresh_ivl_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  // controller state, updated once per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_speed_r     <= '0;
      goal_speed_r    <= '0;
      dir_cw_r        <= 1'b0;
      ramping_r       <= 1'b0;
      ramp_timer_r    <= '0;
      refresh_timer_r <= '0;
      actual_speed_r  <= '0;
      fault_r         <= '0;
    end else if (in_fire) begin
      set_speed_r     <= set_speed_nxt;
      goal_speed_r    <= goal_speed_nxt;
      dir_cw_r        <= dir_cw_nxt;
      ramping_r       <= ramping_nxt;
      ramp_timer_r    <= ramp_timer_nxt;
      refresh_timer_r <= refresh_timer_nxt;
      actual_speed_r  <= actual_speed_nxt;
      fault_r         <= fault_nxt;
    end
  end

  // result count; a push only happens once the register is empty or draining
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (in_fire) begin
      cnt_r <= res_cnt;
    end else if (out_fire) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      slot0_r <= res0;
      slot1_r <= res1;
    end else if (out_fire) begin
      slot0_r <= slot1_r;
    end
  end

endmodule

// File: tb/sv/msc_result_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// msc_result_checker
// Watches the three channels of the speed controller, predicts the drive
// commands and reply frames of every input transaction and compares them.
// ---------------------------------------------------------------------------
module msc_result_checker import msc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  msc_in_if           in_ch,
  msc_out_if          out_ch,
  msc_cfg_if          cfg_ch,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned MIN_SPEED_LEN = 3;
  localparam int unsigned MIN_DIR_LEN   = 2;

  // register copies
  logic [ID_W-1:0]   node_addr;
  logic [SPD_W-1:0]  speed_cap, step_size, step_ivl, refresh_ivl;

  // controller state
  logic [SPD_W-1:0]  cmd_speed, goal_speed, step_ticks, refresh_ticks, fb_speed;
  logic [BYTE_W-1:0] fb_fault;
  logic              dir_cw, stepping_down;

  res_t        due_results[$];
  int unsigned n_results;

  function automatic string show(input res_t r);
    return $sformatf("tgt=%0d kind=%0d w1=%04h w2=%04h st=%02h cw=%0d spd=%04h last=%0d",
                     r.target, r.reply_kind, r.word_one, r.word_two, r.status_code,
                     r.clockwise, r.drive_speed, r.last);
  endfunction

  task automatic queue_drive(input logic [SPD_W-1:0] spd);
    res_t r;
    r             = '0;
    r.target      = TGT_DRIVE;
    r.clockwise   = dir_cw;
    r.drive_speed = spd;
    due_results.push_back(r);
  endtask

  task automatic queue_reply(input logic [KIND_W-1:0] kind, input logic [SPD_W-1:0] w1,
                             input logic [SPD_W-1:0] w2, input logic [BYTE_W-1:0] st);
    res_t r;
    r             = '0;
    r.target      = TGT_REPLY;
    r.reply_kind  = kind;
    r.word_one    = w1;
    r.word_two    = w2;
    r.status_code = st;
    due_results.push_back(r);
  endtask

  // expected results of the transaction on in_ch, state advanced to match
  task automatic predict_item();
    logic [SPD_W-1:0] req;
    logic [SPD_W-1:0] clamped;
    res_t             tail;
    int unsigned      prior;
    prior = due_results.size();
    case (in_ch.func)
      FUNC_FRAME: begin
        if (in_ch.frame_id == node_addr) begin
          if (in_ch.frame_length == '0) begin
            queue_reply(KIND_ERROR, '0, '0, ST_EMPTY);
          end else begin
            case (in_ch.opcode_byte)
              OP_SPEED: begin
                if (in_ch.frame_length >= MIN_SPEED_LEN) begin
                  req     = {in_ch.arg_high, in_ch.arg_low};
                  clamped = (req > speed_cap) ? speed_cap : req;
                  if (clamped < cmd_speed) begin
                    // slow down in steps, no drive command yet
                    goal_speed    = clamped;
                    stepping_down = 1'b1;
                    step_ticks    = '0;
                  end else begin
                    cmd_speed     = clamped;
                    goal_speed    = clamped;
                    stepping_down = 1'b0;
                    queue_drive(cmd_speed);
                  end
                  queue_reply(KIND_SPEED_ACK, req, '0, ST_OK);
                end else begin
                  queue_reply(KIND_ERROR, '0, '0, ST_SHORT);
                end
              end
              OP_DIR: begin
                if (in_ch.frame_length >= MIN_DIR_LEN) begin
                  dir_cw = (in_ch.arg_high != '0);
                  queue_drive(cmd_speed);
                  queue_reply(KIND_DIR_ACK, {{(SPD_W-1){1'b0}}, dir_cw}, '0, ST_OK);
                end else begin
                  queue_reply(KIND_ERROR, '0, '0, ST_SHORT);
                end
              end
              OP_STOP: begin
                cmd_speed     = '0;
                goal_speed    = '0;
                stepping_down = 1'b0;
                queue_drive('0);
                queue_reply(KIND_STOP_ACK, '0, '0, ST_OK);
              end
              OP_STATUS: begin
                queue_reply(KIND_STATUS, fb_speed, {dir_cw, cmd_speed[SPD_W-2:0]}, fb_fault);
              end
              default: begin
                queue_reply(KIND_ERROR, '0, '0, ST_UNKNOWN);
              end
            endcase
          end
        end
      end
      FUNC_TICK: begin
        if (stepping_down) begin
          if (step_ticks != TIMER_MAX) step_ticks = step_ticks + 1'b1;
          if (step_ticks > step_ivl) begin
            step_ticks = '0;
            // 17-bit sum, no wrap
            if ({1'b0, cmd_speed} > ({1'b0, goal_speed} + {1'b0, step_size})) begin
              cmd_speed = cmd_speed - step_size;
            end else begin
              cmd_speed     = goal_speed;
              stepping_down = 1'b0;
            end
            queue_drive(cmd_speed);
          end
        end
        if (refresh_ticks != TIMER_MAX) refresh_ticks = refresh_ticks + 1'b1;
        if (refresh_ticks > refresh_ivl) begin
          refresh_ticks = '0;
          queue_drive(cmd_speed);
        end
      end
      FUNC_REPORT: begin
        fb_speed = in_ch.reported_speed;
        fb_fault = in_ch.reported_fault;
      end
      default: ;
    endcase
    if (due_results.size() > prior) begin
      tail      = due_results.pop_back();
      tail.last = 1'b1;
      due_results.push_back(tail);
    end
  endtask

  task automatic check_result();
    res_t got;
    res_t want;
    got.target      = out_ch.target;
    got.reply_kind  = out_ch.reply_kind;
    got.word_one    = out_ch.word_one;
    got.word_two    = out_ch.word_two;
    got.status_code = out_ch.status_code;
    got.clockwise   = out_ch.clockwise;
    got.drive_speed = out_ch.drive_speed;
    got.last        = out_ch.last;
    n_results++;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("result %0d arrived with nothing expected: %s", n_results, show(got));
    end else begin
      want = due_results.pop_front();
      if (got.target !== want.target || got.reply_kind !== want.reply_kind ||
          got.word_one !== want.word_one || got.word_two !== want.word_two ||
          got.status_code !== want.status_code || got.clockwise !== want.clockwise ||
          got.drive_speed !== want.drive_speed || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("result %0d mismatch", n_results);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    end
  endtask

  // outputs before inputs: a result never leaves in its own accept cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      node_addr     = RST_NODE_ADDR;
      speed_cap     = RST_MAX_SPEED;
      step_size     = RST_RAMP_STEP;
      step_ivl      = RST_RAMP_IVL;
      refresh_ivl   = RST_REFRESH_IVL;
      cmd_speed     = '0;
      goal_speed    = '0;
      step_ticks    = '0;
      refresh_ticks = '0;
      fb_speed      = '0;
      fb_fault      = '0;
      dir_cw        = 1'b0;
      stepping_down = 1'b0;
      n_results     = 0;
      mismatches    = 0;
      due_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.idx)
          CFG_NODE_ADDR:   node_addr   = cfg_ch.data[ID_W-1:0];
          CFG_MAX_SPEED:   speed_cap   = cfg_ch.data;
          CFG_RAMP_STEP:   step_size   = cfg_ch.data;
          CFG_RAMP_IVL:    step_ivl    = cfg_ch.data;
          CFG_REFRESH_IVL: refresh_ivl = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) predict_item();
    end
    outstanding = due_results.size();
  end

endmodule

// File: tb/sv/motor_speed_command_controller_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// motor_speed_command_controller_unit_tb
// Drives command frames, millisecond ticks and inverter reports into the
// speed controller under changing register settings, with random stalls on
// both channels; the checker beside the block predicts and compares results.
// ---------------------------------------------------------------------------
module motor_speed_command_controller_unit_tb import msc_pkg::*; ();

  localparam int unsigned HOLD_CYCLES     = 300;   // long result-side hold-off
  localparam int unsigned IDLE_LIMIT      = 4000;  // cycles with no transaction at all
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned TOP_IVL_TICKS   = 20;    // ticks with both intervals at the top
  localparam int unsigned PHASE_ITEMS     = 120;
  localparam int unsigned BURST_ITEMS     = 24;
  localparam logic [CIDX_W-1:0] CFG_SPARE_IDX = 3'd7;
  localparam logic [FUNC_W-1:0] FUNC_SPARE    = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   frame_id;
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] opcode_byte;
    logic [BYTE_W-1:0] arg_high;
    logic [BYTE_W-1:0] arg_low;
    logic [SPD_W-1:0]  reported_speed;
    logic [BYTE_W-1:0] reported_fault;
  } item_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  msc_in_if  in_ch();
  msc_out_if out_ch();
  msc_cfg_if cfg_ch();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned idle_cycles = 0;

  // hold-off requests from the stimulus, served by the result sink
  int unsigned hold_reqs   = 0;
  int unsigned hold_served = 0;
  bit          tx_calm     = 1'b0;
  bit          rx_calm     = 1'b0;

  // mirror of the registers as written, for addressing frames and picking speeds
  logic [ID_W-1:0]  cur_addr = RST_NODE_ADDR;
  logic [SPD_W-1:0] cur_max  = RST_MAX_SPEED;

  motor_speed_command_controller_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  msc_result_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #1 clk = ~clk;

  // Idle stretch length: mostly none, some short, a few long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Every field random, so that unused fields toggle too.
  function automatic item_t junk_item();
    item_t it;
    it.func           = FUNC_W'($urandom);
    it.frame_id       = ID_W'($urandom);
    it.frame_length   = LEN_W'($urandom);
    it.opcode_byte    = BYTE_W'($urandom);
    it.arg_high       = BYTE_W'($urandom);
    it.arg_low        = BYTE_W'($urandom);
    it.reported_speed = SPD_W'($urandom);
    it.reported_fault = BYTE_W'($urandom);
    return it;
  endfunction

  // Frame addressed to this node.
  function automatic item_t cmd(input logic [BYTE_W-1:0] op, input logic [LEN_W-1:0] len,
                                input logic [BYTE_W-1:0] hi, input logic [BYTE_W-1:0] lo);
    item_t it;
    it              = junk_item();
    it.func         = FUNC_FRAME;
    it.frame_id     = cur_addr;
    it.frame_length = len;
    it.opcode_byte  = op;
    it.arg_high     = hi;
    it.arg_low      = lo;
    return it;
  endfunction

  function automatic item_t ticker();
    item_t it;
    it      = junk_item();
    it.func = FUNC_TICK;
    return it;
  endfunction

  function automatic item_t inv_report(input logic [SPD_W-1:0] spd,
                                       input logic [BYTE_W-1:0] flt);
    item_t it;
    it                = junk_item();
    it.func           = FUNC_REPORT;
    it.reported_speed = spd;
    it.reported_fault = flt;
    return it;
  endfunction

  // Random traffic: mostly well-formed frames for this node and ticks, so
  // that ramps get going and finish; the rest foreign, short or odd items.
  function automatic item_t rand_item();
    item_t            it;
    int unsigned      r;
    logic [LEN_W-1:0] len;
    logic [BYTE_W-1:0] op;
    logic [SPD_W-1:0] spd;
    int unsigned      top;
    it = junk_item();
    r  = $urandom_range(0, 99);
    if (r < 52) begin
      r = $urandom_range(0, 9);
      if (r == 0)      len = LEN_W'($urandom_range(0, 2));
      else if (r == 1) len = LEN_W'($urandom_range(9, 15));
      else             len = LEN_W'($urandom_range(3, 8));
      r = $urandom_range(0, 19);
      if (r < 6)       op = OP_SPEED;
      else if (r < 10) op = OP_DIR;
      else if (r < 12) op = OP_STOP;
      else if (r < 16) op = OP_STATUS;
      else             op = BYTE_W'($urandom);
      case ($urandom_range(0, 3))
        0: spd = SPD_W'($urandom);
        1: spd = SPD_W'($urandom_range(0, cur_max));
        2: begin
          top = cur_max + $urandom_range(0, 5);
          spd = (top > 65535) ? SPD_W'(65535) : SPD_W'(top);
        end
        default: spd = SPD_W'($urandom_range(0, cur_max / 2));
      endcase
      if (op == OP_DIR && $urandom_range(0, 1) == 0) spd[SPD_W-1 -: BYTE_W] = '0;
      it = cmd(op, len, spd[SPD_W-1 -: BYTE_W], spd[BYTE_W-1:0]);
      // a slice of these go to some other node
      if ($urandom_range(0, 6) == 0) it.frame_id = ID_W'($urandom);
    end else if (r < 82) begin
      it.func = FUNC_TICK;
    end else if (r < 94) begin
      it.func = FUNC_REPORT;
    end else begin
      it.func = FUNC_SPARE;
    end
    return it;
  endfunction

  // Present one transaction and wait for it to be taken. Called and
  // returns at a falling edge; valid is left high for a following item.
  task automatic offer(input item_t it);
    int unsigned gap;
    gap = tx_calm ? 0 : gap_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.func           <= it.func;
    in_ch.frame_id       <= it.frame_id;
    in_ch.frame_length   <= it.frame_length;
    in_ch.opcode_byte    <= it.opcode_byte;
    in_ch.arg_high       <= it.arg_high;
    in_ch.arg_low        <= it.arg_low;
    in_ch.reported_speed <= it.reported_speed;
    in_ch.reported_fault <= it.reported_fault;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Stop sending, let every expected result out, then a few spare cycles
  // in case the last item was one that gives no result.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One register write; cfg valid is left high for a following write.
  task automatic put_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_config(input logic [ID_W-1:0] addr, input logic [SPD_W-1:0] cap,
                              input logic [SPD_W-1:0] step, input logic [SPD_W-1:0] ramp_ivl,
                              input logic [SPD_W-1:0] refr_ivl);
    // junk above the 11-bit address must be dropped
    put_reg(CFG_NODE_ADDR, {(CDATA_W-ID_W)'($urandom), addr});
    put_reg(CFG_MAX_SPEED, cap);
    put_reg(CFG_RAMP_STEP, step);
    put_reg(CFG_RAMP_IVL, ramp_ivl);
    put_reg(CFG_REFRESH_IVL, refr_ivl);
    cfg_ch.valid <= 1'b0;
    cur_addr = addr;
    cur_max  = cap;
  endtask

  // Result side: random back-pressure, calm stretches, and the long
  // hold-off whenever the stimulus asks for one.
  initial begin : result_sink
    int unsigned n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_served) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_served++;
      end else if (rx_calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        n = gap_len();
        if (n == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  // Watchdog: any transaction on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[motor_speed_command_controller_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned p;
    int unsigned k;
    int unsigned j;
    item_t       it;

    in_ch.valid          = 1'b0;
    in_ch.func           = FUNC_FRAME;
    in_ch.frame_id       = '0;
    in_ch.frame_length   = '0;
    in_ch.opcode_byte    = '0;
    in_ch.arg_high       = '0;
    in_ch.arg_low        = '0;
    in_ch.reported_speed = '0;
    in_ch.reported_fault = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.idx           = CFG_NODE_ADDR;
    cfg_ch.data          = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed, register values from reset ----
    offer(cmd(OP_STATUS, 4'd1, 8'h00, 8'h00));         // status of a fresh block
    it          = cmd(OP_SPEED, 4'd3, 8'h01, 8'h00);
    it.frame_id = cur_addr ^ {ID_W{1'b1}};             // foreign frame, silent
    offer(it);
    offer(cmd(OP_SPEED, 4'd0, 8'h01, 8'h00));          // empty frame
    offer(cmd(OP_SPEED, 4'd2, 8'h01, 8'h00));          // speed frame too short
    offer(cmd(OP_SPEED, 4'd3, 8'hFF, 8'hFF));          // clamped to max, ack keeps request
    offer(cmd(OP_SPEED, 4'd8, 8'h03, 8'hE8));          // lower speed: ack only, ramp starts
    offer(cmd(OP_DIR, 4'd1, 8'h80, 8'h00));            // direction frame too short
    offer(cmd(OP_DIR, 4'd2, 8'h80, 8'h00));            // clockwise
    offer(inv_report(16'hFFFF, 8'hFF));
    offer(cmd(OP_STATUS, 4'd15, 8'h00, 8'h00));        // long frame acts as full
    offer(cmd(8'hFF, 4'd4, 8'h00, 8'h00));             // unknown command
    offer(cmd(8'h00, 4'd1, 8'h00, 8'h00));
    it      = junk_item();
    it.func = FUNC_SPARE;                              // unused kind, ignored
    offer(it);
    offer(cmd(OP_STOP, 4'd1, 8'hFF, 8'hFF));
    offer(cmd(OP_DIR, 4'd8, 8'h00, 8'hFF));            // back to counter-clockwise
    offer(inv_report(16'h0000, 8'h00));

    // ---- directed, fast timers so that ramp steps and refreshes show ----
    settle();
    put_reg(CFG_SPARE_IDX, 16'hFFFF);                  // index past the list, dropped
    write_config(11'h000, 16'hFFFF, 16'd100, 16'd1, 16'd2);
    offer(cmd(OP_SPEED, 4'd3, 8'hFF, 8'hFF));
    offer(cmd(OP_SPEED, 4'd3, 8'hFF, 8'h14));          // 65300: ramp down in steps of 100
    repeat (5) offer(ticker());
    it          = cmd(OP_STATUS, 4'd3, 8'h00, 8'h00);
    it.frame_id = {ID_W{1'b1}};
    offer(it);

    // ---- intervals at the top: no ramp step and no refresh for a while ----
    settle();
    write_config(cur_addr, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
    offer(cmd(OP_SPEED, 4'd3, 8'h9C, 8'h40));
    offer(cmd(OP_SPEED, 4'd3, 8'h00, 8'h64));
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    for (k = 0; k < TOP_IVL_TICKS; k++) offer(ticker());
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    // ---- random phases, register extremes among them ----
    for (p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: write_config(11'h7FF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        1: write_config(ID_W'($urandom), 16'd3000, 16'd0, 16'd2, 16'hFFFF); // ramp never ends
        2: write_config(11'h000, 16'd0, 16'd1, 16'hFFFF, 16'd1);
        default: write_config(ID_W'($urandom), SPD_W'($urandom_range(500, 65535)),
                              SPD_W'($urandom_range(1, 500)), SPD_W'($urandom_range(0, 5)),
                              SPD_W'($urandom_range(0, 20)));
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) begin
          tx_calm = ($urandom_range(0, 3) == 0);
          rx_calm = ($urandom_range(0, 3) == 0);
        end
        if (p == 1 && k == 50) begin
          // result side holds off while two-result frames keep coming
          hold_reqs++;
          tx_calm = 1'b1;
          for (j = 0; j < BURST_ITEMS; j++)
            offer(cmd(OP_DIR, 4'd2, BYTE_W'($urandom), BYTE_W'($urandom)));
          tx_calm = 1'b0;
        end
        if (p == 2 && k == 70) settle();  // sender pauses until all is out
        offer(rand_item());
      end
    end

    // ---- wind down ----
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("[motor_speed_command_controller_unit] OK");
    end else begin
      $display("[motor_speed_command_controller_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/msc_pkg.sv
rtl/core/msc_if.sv
rtl/core/motor_speed_command_controller_unit.sv
tb/sv/msc_result_checker.sv
tb/sv/motor_speed_command_controller_unit_tb.sv
